/* rtl/mgfi_pkg.sv */
// package: shared types, constants and controller encodings for the frequent-items block
package mgfi_pkg;

   localparam int CFG_W       = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;

   localparam logic [CFG_W-1:0]       CFG_COUNTERS_RESET = 5'd15;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNTERS_IN_USE = 1'b0;

   typedef logic signed [31:0] key_type;
   typedef logic [31:0]        count_type;

   localparam count_type COUNT_MAX = 32'hFFFF_FFFF;
   localparam count_type COUNT_ONE = 32'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_READOUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic idx_clear;
      logic load_out;
      logic idx_step;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic item_last;
      logic out_free;
      logic idx_last;
   } status_type;

endpackage

/* rtl/mgfi_req_if.sv */
// interface: input word channel carrying a key and the end-of-stream mark
interface mgfi_req_if;
   import mgfi_pkg::*;

   logic    valid;
   logic    ready;
   key_type item_key;
   logic    end_of_stream;

   modport source (output valid, output item_key, output end_of_stream, input ready);
   modport sink   (input valid, input item_key, input end_of_stream, output ready);
endinterface

/* rtl/mgfi_rsp_if.sv */
// interface: result word channel carrying one slot of the candidate readout
interface mgfi_rsp_if;
   import mgfi_pkg::*;

   logic      valid;
   logic      ready;
   logic      slot_valid;
   key_type   candidate_key;
   count_type candidate_count;
   logic      run_last;

   modport source (output valid, output slot_valid, output candidate_key,
                   output candidate_count, output run_last, input ready);
   modport sink   (input valid, input slot_valid, input candidate_key,
                   input candidate_count, input run_last, output ready);
endinterface

/* rtl/mgfi_ctrl.sv */
// controller: sequences capture, table update and slot readout
module mgfi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  mgfi_pkg::status_type status,
   output mgfi_pkg::cmd_type    cmd,
   output logic                 req_ready
);
   import mgfi_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.item_last ? ST_READOUT : ST_IDLE;
         end
         ST_READOUT: begin
            if (status.out_free && status.idx_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = status.req_valid;
         end
         ST_UPDATE: begin
            cmd.update    = 1'b1;
            cmd.idx_clear = 1'b1;
         end
         ST_READOUT: begin
            cmd.load_out = status.out_free;
            cmd.idx_step = status.out_free;
            cmd.clear    = status.out_free && status.idx_last;
         end
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/mgfi_datapath.sv */
// datapath: slot table, parallel match and decrement, readout index and output register
module mgfi_datapath #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mgfi_pkg::cmd_type           cmd,
   output mgfi_pkg::status_type        status,
   input  logic [mgfi_pkg::CFG_W-1:0]  cfg_counters,
   input  logic                        req_valid,
   input  mgfi_pkg::key_type           req_key,
   input  logic                        req_last,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_slot_valid,
   output mgfi_pkg::key_type           rsp_key,
   output mgfi_pkg::count_type         rsp_count,
   output logic                        rsp_run_last
);
   import mgfi_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   key_type             key_ff;
   logic                last_ff;
   key_type             slot_key_ff   [TABLE_SLOTS];
   count_type           slot_count_ff [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] slot_used_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                out_valid_ff;
   logic                out_slot_valid_ff;
   key_type             out_key_ff;
   count_type           out_count_ff;
   logic                out_last_ff;

   logic [CNT_W-1:0]       n_active;
   logic [CMP_W-1:0]       cfg_wide;
   logic [TABLE_SLOTS-1:0] active;
   logic [TABLE_SLOTS-1:0] hit_vec;
   logic [TABLE_SLOTS-1:0] free_vec;
   logic [TABLE_SLOTS-1:0] first_hit;
   logic [TABLE_SLOTS-1:0] first_free;
   logic                   any_hit;
   logic                   any_free;
   logic                   idx_last;
   logic                   out_free;

   // clamp the slot count to 1..TABLE_SLOTS
   always_comb begin
      cfg_wide = CMP_W'(cfg_counters);
      if (cfg_wide == '0) begin
         n_active = CNT_W'(1);
      end else if (cfg_wide > CMP_W'(TABLE_SLOTS)) begin
         n_active = CNT_W'(TABLE_SLOTS);
      end else begin
         n_active = CNT_W'(cfg_counters);
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         active[i]   = CNT_W'(i) < n_active;
         hit_vec[i]  = slot_used_ff[i] && active[i] && (slot_key_ff[i] == key_ff);
         free_vec[i] = !slot_used_ff[i] && active[i];
      end
      first_hit  = hit_vec & (~hit_vec + TABLE_SLOTS'(1));
      first_free = free_vec & (~free_vec + TABLE_SLOTS'(1));
      any_hit    = |hit_vec;
      any_free   = |free_vec;
   end

   assign idx_last = CNT_W'(idx_ff) == (n_active - CNT_W'(1));
   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff  <= req_key;
         last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) slot_count_ff[i] <= '0;
      end else if (cmd.clear) begin
         slot_used_ff <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) slot_count_ff[i] <= '0;
      end else if (cmd.update) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (any_hit) begin
               if (first_hit[i] && slot_count_ff[i] != COUNT_MAX) begin
                  slot_count_ff[i] <= slot_count_ff[i] + COUNT_ONE;
               end
            end else if (any_free) begin
               if (first_free[i]) begin
                  slot_key_ff[i]   <= key_ff;
                  slot_count_ff[i] <= COUNT_ONE;
                  slot_used_ff[i]  <= 1'b1;
               end
            end else if (slot_used_ff[i] && active[i]) begin
               // a used slot never holds zero, so one means it empties now
               slot_count_ff[i] <= slot_count_ff[i] - COUNT_ONE;
               if (slot_count_ff[i] == COUNT_ONE) slot_used_ff[i] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_slot_valid_ff <= slot_used_ff[idx_ff];
         out_key_ff        <= slot_used_ff[idx_ff] ? slot_key_ff[idx_ff] : '0;
         out_count_ff      <= slot_used_ff[idx_ff] ? slot_count_ff[idx_ff] : '0;
         out_last_ff       <= idx_last;
      end
   end

   assign status.req_valid = req_valid;
   assign status.item_last = last_ff;
   assign status.out_free  = out_free;
   assign status.idx_last  = idx_last;

   assign rsp_valid      = out_valid_ff;
   assign rsp_slot_valid = out_slot_valid_ff;
   assign rsp_key        = out_key_ff;
   assign rsp_count      = out_count_ff;
   assign rsp_run_last   = out_last_ff;

endmodule

/* rtl/misra_gries_frequent_items.sv */
// top level: frequent-item summary with register port, controller and datapath
//
// channel   direction  payload
// req_port  in         item_key, end_of_stream
// rsp_port  out        slot_valid, candidate_key, candidate_count, run_last
// csr_*     in/out     counters_in_use at byte address 0
//
// an item is handled in ST_IDLE, which captures the word, then in ST_UPDATE, which updates the slot table
// an end-of-stream item then reads out one word per active slot, one per cycle
// while the output register drains, then clears the table in the cycle of the last load
// rsp_ready low stalls the readout; no item is taken during the update or readout
// reset empties the table and sets counters_in_use to 15
module misra_gries_frequent_items #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   mgfi_req_if.sink                           req_port,
   mgfi_rsp_if.source                         rsp_port,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mgfi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mgfi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mgfi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import mgfi_pkg::*;

   logic [CFG_W-1:0]       counters_ff;
   logic [CSR_INDEX_W-1:0] csr_index;
   cmd_type                cmd;
   status_type             status;
   logic                   ready;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         counters_ff <= CFG_COUNTERS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_index == REG_COUNTERS_IN_USE) begin
         counters_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_COUNTERS_IN_USE) csr_prdata = CSR_DATA_W'(counters_ff);
   end

   mgfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (ready)
   );

   assign req_port.ready = ready;

   mgfi_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg_counters   (counters_ff),
      .req_valid      (req_port.valid),
      .req_key        (req_port.item_key),
      .req_last       (req_port.end_of_stream),
      .rsp_ready      (rsp_port.ready),
      .rsp_valid      (rsp_port.valid),
      .rsp_slot_valid (rsp_port.slot_valid),
      .rsp_key        (rsp_port.candidate_key),
      .rsp_count      (rsp_port.candidate_count),
      .rsp_run_last   (rsp_port.run_last)
   );

endmodule

/* dv/misra_gries_frequent_items_checker.sv */
// checker: tracks the slot table from observed words, compares every candidate readout and every counters_in_use read
module misra_gries_frequent_items_checker #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   mgfi_req_if                             req_mon,
   mgfi_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mgfi_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mgfi_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [mgfi_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int unsigned                     mismatches,
   output int unsigned                     outstanding
);
   import mgfi_pkg::*;

   typedef struct packed {
      logic      slot_valid;
      key_type   candidate_key;
      count_type candidate_count;
      logic      run_last;
   } candidate_word_type;

   key_type            table_key [TABLE_SLOTS];
   count_type          table_count [TABLE_SLOTS];
   logic               table_held [TABLE_SLOTS];
   logic [CFG_W-1:0]   slots_setting;
   candidate_word_type expected_candidates [$];

   function automatic int unsigned live_slots();
      if (slots_setting == 0) return 1;
      if (slots_setting > TABLE_SLOTS) return TABLE_SLOTS;
      return int'(slots_setting);
   endfunction

   task automatic clear_table();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         table_key[i]   = '0;
         table_count[i] = '0;
         table_held[i]  = 1'b0;
      end
   endtask

   task automatic absorb_key(input key_type key, input logic last);
      int unsigned        n;
      int                 free_slot;
      bit                 hit;
      candidate_word_type word;
      n         = live_slots();
      hit       = 1'b0;
      free_slot = -1;
      for (int i = 0; i < n; i++) begin
         if (!hit && table_held[i] && table_key[i] == key) begin
            if (table_count[i] != COUNT_MAX) table_count[i] = table_count[i] + 1;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         for (int i = 0; i < n; i++) begin
            if (free_slot < 0 && !table_held[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            table_key[free_slot]   = key;
            table_count[free_slot] = COUNT_ONE;
            table_held[free_slot]  = 1'b1;
         end else begin
            for (int i = 0; i < n; i++) begin
               if (table_held[i]) begin
                  if (table_count[i] != 0) table_count[i] = table_count[i] - 1;
                  if (table_count[i] == 0) begin
                     table_held[i] = 1'b0;
                     table_key[i]  = '0;
                  end
               end
            end
         end
      end
      if (last) begin
         for (int i = 0; i < n; i++) begin
            word.slot_valid      = table_held[i];
            word.candidate_key   = table_held[i] ? table_key[i] : '0;
            word.candidate_count = table_held[i] ? table_count[i] : '0;
            word.run_last        = (i == n - 1);
            expected_candidates  = {expected_candidates, word};
         end
         clear_table();
      end
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
   endtask

   task automatic compare_candidate();
      candidate_word_type want;
      if (expected_candidates.size() == 0) begin
         $display("%0t: unexpected candidate word, expected none, actual %b %h %h %b",
                  $time, rsp_mon.slot_valid, rsp_mon.candidate_key,
                  rsp_mon.candidate_count, rsp_mon.run_last);
         mismatches++;
      end else begin
         want = expected_candidates.pop_front();
         if (rsp_mon.slot_valid !== want.slot_valid)
            report_field("slot_valid", want.slot_valid, rsp_mon.slot_valid);
         if (rsp_mon.candidate_key !== want.candidate_key)
            report_field("candidate_key", want.candidate_key, rsp_mon.candidate_key);
         if (rsp_mon.candidate_count !== want.candidate_count)
            report_field("candidate_count", want.candidate_count, rsp_mon.candidate_count);
         if (rsp_mon.run_last !== want.run_last)
            report_field("run_last", want.run_last, rsp_mon.run_last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         slots_setting = CFG_COUNTERS_RESET;
         expected_candidates.delete();
         mismatches = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) compare_candidate();
         if (req_mon.valid && req_mon.ready) absorb_key(req_mon.item_key, req_mon.end_of_stream);
         if (csr_psel && csr_penable && csr_pready
             && csr_paddr[CSR_ADDR_W-1:2] == REG_COUNTERS_IN_USE) begin
            if (csr_pwrite) begin
               slots_setting = csr_pwdata[CFG_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(slots_setting)) begin
               $display("%0t: counters_in_use read mismatch, expected %h, actual %h",
                        $time, CSR_DATA_W'(slots_setting), csr_prdata);
               mismatches++;
            end
         end
      end
      outstanding = expected_candidates.size();
   end

endmodule

/* dv/misra_gries_frequent_items_tb.sv */
// testbench top: clock, reset, key streams, register writes and the final verdict
module misra_gries_frequent_items_tb;
   import mgfi_pkg::*;

   localparam int                     STALL_LIMIT  = 3000;
   localparam int                     QUIET_CYCLES = 8;
   localparam int                     HOLD_CYCLES  = 400;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 1'b1;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int unsigned           mismatches;
   int unsigned           outstanding;
   int unsigned           req_idle_pct;
   int unsigned           rsp_idle_pct;
   int unsigned           rsp_holds_asked;
   int unsigned           items_sent;
   int unsigned           idle_cycles;
   key_type               key_pool [$];

   mgfi_req_if req_bus ();
   mgfi_rsp_if rsp_bus ();

   misra_gries_frequent_items dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   misra_gries_frequent_items_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned holds_done;
      holds_done    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holds_asked != holds_done) begin
            holds_done    = holds_done + 1;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("misra_gries_frequent_items verification failed");
      $finish;
   end

   task automatic put_word(input key_type key, input logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid         = 1'b1;
      req_bus.item_key      = key;
      req_bus.end_of_stream = last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic go_quiet();
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_INDEX_W-1:0] index,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_slots(input logic [CFG_W-1:0] slots);
      go_quiet();
      csr_access(1'b1, REG_COUNTERS_IN_USE,
                 {27'($urandom_range(0, 32'h07FF_FFFF)), slots});
      csr_access(1'b0, REG_COUNTERS_IN_USE, '0);
   endtask

   function automatic logic [CFG_W-1:0] pick_setting();
      case ($urandom_range(0, 7))
         0:       return CFG_W'(0);
         1:       return CFG_W'(1);
         2:       return CFG_W'(16);
         3:       return CFG_W'(31);
         4:       return CFG_W'(15);
         default: return CFG_W'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic key_type pick_key();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return key_pool[0];
      if (roll < 75) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (roll < 95) return $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic random_stream(input int unsigned length);
      key_pool.delete();
      repeat ($urandom_range(2, 20)) key_pool = {key_pool, key_type'($urandom)};
      for (int unsigned i = 0; i < length; i++) begin
         if (i == length / 2 && length > 2 && $urandom_range(0, 9) == 0)
            set_slots(pick_setting());
         put_word(pick_key(), i == length - 1);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.item_key      = '0;
      req_bus.end_of_stream = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_idle_pct          = 14;
      rsp_idle_pct          = 46;
      rsp_holds_asked       = 0;
      items_sent            = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setting, extreme keys, most slots left free
      put_word(32'h8000_0000, 1'b0);
      put_word(32'h7FFF_FFFF, 1'b0);
      put_word(32'h0000_0000, 1'b0);
      put_word(32'hFFFF_FFFF, 1'b0);
      put_word(32'h7FFF_FFFF, 1'b0);
      put_word(32'h8000_0000, 1'b1);

      // single slot: hits, decrement to zero, refill
      set_slots(CFG_W'(1));
      put_word(32'd5, 1'b0);
      put_word(32'd5, 1'b0);
      put_word(32'd9, 1'b0);
      put_word(32'd9, 1'b0);
      put_word(32'd12, 1'b0);
      put_word(32'd12, 1'b1);

      // zero setting acts as one slot, unmapped write has no effect
      set_slots(CFG_W'(0));
      put_word(32'h5555_5555, 1'b1);
      go_quiet();
      csr_access(1'b1, REG_UNMAPPED, 32'd3);
      put_word(32'hAAAA_AAAA, 1'b1);

      // oversized setting, then lowered in mid-stream
      set_slots(CFG_W'(31));
      for (int k = 1; k <= 6; k++) put_word(k, 1'b0);
      set_slots(CFG_W'(3));
      put_word(32'd1, 1'b0);
      put_word(32'h99, 1'b0);
      put_word(32'h77, 1'b1);

      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 46 : 0;
         rsp_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 14 : 0;
         set_slots(pick_setting());
         if (mode == 0) begin
            // long receiver hold while further streams are offered
            rsp_holds_asked = rsp_holds_asked + 1;
            random_stream(3);
            random_stream(5);
            random_stream(2);
         end
         while (items_sent < 23 + (mode + 1) * 136) begin
            if ($urandom_range(0, 9) < 3) set_slots(pick_setting());
            else if ($urandom_range(0, 9) < 2) go_quiet();
            random_stream(($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                                      : $urandom_range(1, 25));
         end
      end

      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("misra_gries_frequent_items verification clean");
      else
         $display("misra_gries_frequent_items verification failed");
      $finish;
   end

endmodule

/* misra_gries_frequent_items.f */
rtl/mgfi_pkg.sv
rtl/mgfi_req_if.sv
rtl/mgfi_rsp_if.sv
rtl/mgfi_ctrl.sv
rtl/mgfi_datapath.sv
rtl/misra_gries_frequent_items.sv
dv/misra_gries_frequent_items_checker.sv
dv/misra_gries_frequent_items_tb.sv
